// ===== sv/sphpf_pkg.sv =====
`timescale 1ns / 1ps

package sphpf_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQRT,
    ST_EPS,
    ST_D2,
    ST_T,
    ST_K,
    ST_A1,
    ST_A2,
    ST_B1,
    ST_B2,
    ST_C,
    ST_GX,
    ST_FX,
    ST_GY,
    ST_FY,
    ST_POST,
    ST_EX,
    ST_EY,
    ST_OUT
  } state_e;

  // Intermediate magnitudes saturate at 2^62-1.
  localparam int unsigned MAG_W   = 62;
  localparam logic [MAG_W-1:0] MAG_CAP = '1;
  localparam logic [MAG_W-1:0] K3_LIMIT = MAG_CAP / 3;

  // Divisors are densities (32 bits) or r + h*eps (33 bits).
  localparam int unsigned DIV_W = 33;

  // h*eps is floor(h / 1000000), formed as (h * EPS_RECIP) >> EPS_SHIFT.
  // The reciprocal is exact for every 32-bit h.
  localparam logic [63:0] EPS_RECIP = 64'd1125899907;
  localparam int unsigned EPS_SHIFT = 50;

  localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0001;

  localparam logic CFG_SMOOTHING_RADIUS = 1'b0;
  localparam logic CFG_KERNEL_SCALE     = 1'b1;

  localparam logic [31:0] RADIUS_RESET = 32'h0001_0000;
  localparam logic [31:0] SCALE_RESET  = 32'h0001_0000;

  typedef struct packed {
    logic signed [63:0] value;
    logic               clip;
  } acc_res_t;

  typedef struct packed {
    logic [31:0] value;
    logic        clip;
  } force_res_t;

endpackage

// ===== sv/sph_pressure_force_accumulator.sv =====
`timescale 1ns / 1ps
// A pair inside the kernel support runs the full sequence of products and quotients;
// a pair outside support skips to the post step. A last pair adds the two output
// products before the result is offered. A new pair is taken only once the previous one
// is done; a pair in support runs five radix-2 divisions on one shared divider.
// Reset clears the accumulators and clip flag and restores h = 1.0 and scale = 1.0.

module sph_pressure_force_accumulator #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic [31:0]        center_mass_i,
  input  logic [31:0]        center_density_i,
  input  logic [31:0]        center_pressure_i,
  input  logic signed [31:0] other_x_i,
  input  logic signed [31:0] other_y_i,
  input  logic [31:0]        other_mass_i,
  input  logic [31:0]        other_density_i,
  input  logic [31:0]        other_pressure_i,
  input  logic               last_pair_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] force_x_o,
  output logic signed [31:0] force_y_o,
  output logic               saturated_o
);

  localparam int unsigned MAG_W  = sphpf_pkg::MAG_W;
  localparam int unsigned DIV_W  = sphpf_pkg::DIV_W;
  localparam int unsigned NUM_W  = 64 + FRAC_BITS;
  localparam int unsigned DCNT_W = $clog2(NUM_W + 1);
  localparam int unsigned PAD_Q  = NUM_W - MAG_W - FRAC_BITS;
  localparam int unsigned PAD_P  = NUM_W - 32 - FRAC_BITS;

  function automatic sphpf_pkg::acc_res_t sat_acc(input logic signed [63:0] s,
                                                   input logic neg,
                                                   input logic [MAG_W-1:0] mag);
    logic signed [64:0] sum;
    sphpf_pkg::acc_res_t res;
    if (neg) begin
      sum = $signed({s[63], s}) - $signed({3'b000, mag});
    end else begin
      sum = $signed({s[63], s}) + $signed({3'b000, mag});
    end
    res.clip  = 1'b0;
    res.value = sum[63:0];
    if (sum > $signed({1'b0, sphpf_pkg::ACC_MAX})) begin
      res.clip  = 1'b1;
      res.value = sphpf_pkg::ACC_MAX;
    end else if (sum < $signed({1'b1, sphpf_pkg::ACC_MIN})) begin
      res.clip  = 1'b1;
      res.value = sphpf_pkg::ACC_MIN;
    end
    return res;
  endfunction

  // The output force is -m_i * sum, so its sign is opposite to the sum's.
  function automatic sphpf_pkg::force_res_t clamp_force(input logic sum_neg,
                                                        input logic [MAG_W-1:0] mag);
    sphpf_pkg::force_res_t res;
    res.clip = 1'b0;
    if (sum_neg) begin
      if (mag > 62'h7FFF_FFFF) begin
        res.clip  = 1'b1;
        res.value = 32'h7FFF_FFFF;
      end else begin
        res.value = mag[31:0];
      end
    end else begin
      if (mag > 62'h8000_0000) begin
        res.clip  = 1'b1;
        res.value = 32'h8000_0000;
      end else begin
        res.value = ~mag[31:0] + 32'd1;
      end
    end
    return res;
  endfunction

  sphpf_pkg::state_e state_q, state_d;

  logic [31:0] radius_q, scale_q;

  // Latched pair.
  logic signed [32:0] dx_q, dy_q;
  logic [31:0] mi_q, mj_q, pi_q, pj_q, rhoi_q, rhoj_q;
  logic        last_q;

  logic signed [32:0] in_dx, in_dy;
  logic [32:0] in_ax, in_ay, ax_w, ay_w;

  logic [63:0]       sqx_q;
  logic [64:0]       sq_sum;
  logic [DIV_W-1:0]  den_q, den_w;
  logic [31:0]       r_w;
  logic [MAG_W-1:0]  k_q, k3_w, a_q, c_q, ab_sat;
  logic [MAG_W:0]    ab_sum;
  logic              kclip, abclip;

  logic signed [63:0] sum_x_q, sum_y_q;
  logic               clip_seen_q;
  logic [63:0]        abs_x, abs_y;
  sphpf_pkg::acc_res_t   accx, accy;
  sphpf_pkg::force_res_t fxr, fyr;
  logic [31:0]        fx_tmp_q, fy_tmp_q;
  logic               eclip_q;

  logic               out_valid_q;
  logic signed [31:0] force_x_q, force_y_q;
  logic               saturated_q;
  logic               out_load;

  // Shared multiplier: one 32x32 product per cycle, four partial products.
  logic              mul_start;
  logic [63:0]       mul_a, mul_b;
  logic [63:0]       ma_q, mb_q, mprod_q;
  logic [2:0]        mcnt_q;
  logic [1:0]        pidx_q;
  logic              pv_q, mbusy_q, mdone_q;
  logic [127:0]      macc_q, mshift, mterm;
  logic [6:0]        moff;
  logic [31:0]       a_half, b_half;
  logic              mclip;
  logic [MAG_W-1:0]  mmag;

  // Shared restoring divider, one quotient bit per cycle.
  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [DIV_W-1:0]  div_den;
  logic [NUM_W-1:0]  dnum_q, dquo_q;
  logic [DIV_W-1:0]  drem_q, ddiv_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic              dbusy_q, ddone_q;
  logic [DIV_W:0]    dtrial, dsub;
  logic              dge, dclip;
  logic [MAG_W-1:0]  dmag;

  // Integer square root, one result bit per cycle.
  logic              sqrt_start;
  logic [63:0]       sqrt_v;
  logic [63:0]       sv_q, sres_q, sbit_q, strial;
  logic [4:0]        scnt_q;
  logic              sbusy_q, sdone_q, sge;

  assign in_dx = $signed({center_x_i[31], center_x_i}) - $signed({other_x_i[31], other_x_i});
  assign in_dy = $signed({center_y_i[31], center_y_i}) - $signed({other_y_i[31], other_y_i});
  assign in_ax = in_dx[32] ? (~in_dx + 33'd1) : in_dx;
  assign in_ay = in_dy[32] ? (~in_dy + 33'd1) : in_dy;
  assign ax_w  = dx_q[32] ? (~dx_q + 33'd1) : dx_q;
  assign ay_w  = dy_q[32] ? (~dy_q + 33'd1) : dy_q;

  assign sq_sum = {1'b0, sqx_q} + {1'b0, macc_q[63:0]};
  assign r_w    = sres_q[31:0];
  // The raw product h * EPS_RECIP holds h*eps in its top 14 bits.
  assign den_w  = {1'b0, r_w} + {19'b0, macc_q[63:sphpf_pkg::EPS_SHIFT]};

  assign kclip  = mmag > sphpf_pkg::K3_LIMIT;
  assign k3_w   = kclip ? sphpf_pkg::MAG_CAP : (mmag + {mmag[MAG_W-2:0], 1'b0});
  assign ab_sum = {1'b0, a_q} + {1'b0, dmag};
  assign abclip = ab_sum[MAG_W];
  assign ab_sat = abclip ? sphpf_pkg::MAG_CAP : ab_sum[MAG_W-1:0];

  assign abs_x = sum_x_q[63] ? (~sum_x_q + 64'd1) : sum_x_q;
  assign abs_y = sum_y_q[63] ? (~sum_y_q + 64'd1) : sum_y_q;
  // A positive offset pushes the sum down.
  assign accx  = sat_acc(sum_x_q, !dx_q[32] && (dx_q != '0), mmag);
  assign accy  = sat_acc(sum_y_q, !dy_q[32] && (dy_q != '0), mmag);
  assign fxr   = clamp_force(sum_x_q[63], mmag);
  assign fyr   = clamp_force(sum_y_q[63], mmag);

  assign out_load = (state_q == sphpf_pkg::ST_OUT) && (!out_valid_q || out_ready_i);

  // ---------------------------------------------------------------- multiplier
  assign a_half = mcnt_q[1] ? ma_q[63:32] : ma_q[31:0];
  assign b_half = mcnt_q[0] ? mb_q[63:32] : mb_q[31:0];

  always_comb begin
    case (pidx_q)
      2'd0:    moff = 7'd0;
      2'd3:    moff = 7'd64;
      default: moff = 7'd32;
    endcase
  end

  assign mterm  = {64'b0, mprod_q} << moff;
  assign mshift = macc_q >> FRAC_BITS;
  assign mclip  = |mshift[127:MAG_W];
  assign mmag   = mclip ? sphpf_pkg::MAG_CAP : mshift[MAG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
      mdone_q <= 1'b0;
      pv_q    <= 1'b0;
      mcnt_q  <= '0;
    end else begin
      mdone_q <= 1'b0;
      if (mul_start) begin
        mbusy_q <= 1'b1;
        pv_q    <= 1'b0;
        mcnt_q  <= '0;
      end else if (mbusy_q) begin
        pv_q   <= mcnt_q < 3'd4;
        mcnt_q <= mcnt_q + 3'd1;
        if (mcnt_q == 3'd4) begin
          mbusy_q <= 1'b0;
          mdone_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_start) begin
      ma_q   <= mul_a;
      mb_q   <= mul_b;
      macc_q <= '0;
    end else if (mbusy_q) begin
      if (mcnt_q < 3'd4) begin
        mprod_q <= a_half * b_half;
        pidx_q  <= mcnt_q[1:0];
      end
      if (pv_q) begin
        macc_q <= macc_q + mterm;
      end
    end
  end

  // ---------------------------------------------------------------- divider
  assign dtrial = {drem_q, dnum_q[NUM_W-1]};
  assign dsub   = dtrial - {1'b0, ddiv_q};
  assign dge    = dtrial >= {1'b0, ddiv_q};
  assign dclip  = |dquo_q[NUM_W-1:MAG_W];
  assign dmag   = dclip ? sphpf_pkg::MAG_CAP : dquo_q[MAG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      ddone_q <= 1'b0;
      dcnt_q  <= '0;
    end else begin
      ddone_q <= 1'b0;
      if (div_start) begin
        dbusy_q <= 1'b1;
        dcnt_q  <= '0;
      end else if (dbusy_q) begin
        dcnt_q <= dcnt_q + DCNT_W'(1);
        if (dcnt_q == DCNT_W'(NUM_W - 1)) begin
          dbusy_q <= 1'b0;
          ddone_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      dnum_q <= div_num;
      ddiv_q <= div_den;
      drem_q <= '0;
      dquo_q <= '0;
    end else if (dbusy_q) begin
      dnum_q <= {dnum_q[NUM_W-2:0], 1'b0};
      drem_q <= dge ? dsub[DIV_W-1:0] : dtrial[DIV_W-1:0];
      dquo_q <= {dquo_q[NUM_W-2:0], dge};
    end
  end

  // ---------------------------------------------------------------- square root
  assign strial = sres_q + sbit_q;
  assign sge    = sv_q >= strial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbusy_q <= 1'b0;
      sdone_q <= 1'b0;
      scnt_q  <= '0;
    end else begin
      sdone_q <= 1'b0;
      if (sqrt_start) begin
        sbusy_q <= 1'b1;
        scnt_q  <= '0;
      end else if (sbusy_q) begin
        scnt_q <= scnt_q + 5'd1;
        if (scnt_q == 5'd31) begin
          sbusy_q <= 1'b0;
          sdone_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sqrt_start) begin
      sv_q   <= sqrt_v;
      sres_q <= '0;
      sbit_q <= 64'h4000_0000_0000_0000;
    end else if (sbusy_q) begin
      if (sge) begin
        sv_q   <= sv_q - strial;
        sres_q <= (sres_q >> 1) + sbit_q;
      end else begin
        sres_q <= sres_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sphpf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    sqrt_start = 1'b0;
    sqrt_v     = '0;
    case (state_q)
      sphpf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_ax[32] || in_ay[32]) begin
            state_d = sphpf_pkg::ST_POST;
          end else begin
            mul_start = 1'b1;
            mul_a     = {31'b0, in_ax};
            mul_b     = {31'b0, in_ax};
            state_d   = sphpf_pkg::ST_SQX;
          end
        end
      end
      sphpf_pkg::ST_SQX: begin
        if (mdone_q) begin
          mul_start = 1'b1;
          mul_a     = {31'b0, ay_w};
          mul_b     = {31'b0, ay_w};
          state_d   = sphpf_pkg::ST_SQY;
        end
      end
      sphpf_pkg::ST_SQY: begin
        if (mdone_q) begin
          if (sq_sum[64]) begin
            state_d = sphpf_pkg::ST_POST;
          end else begin
            sqrt_start = 1'b1;
            sqrt_v     = sq_sum[63:0];
            state_d    = sphpf_pkg::ST_SQRT;
          end
        end
      end
      sphpf_pkg::ST_SQRT: begin
        if (sdone_q) begin
          mul_start = 1'b1;
          mul_a     = {32'b0, radius_q};
          mul_b     = sphpf_pkg::EPS_RECIP;
          state_d   = sphpf_pkg::ST_EPS;
        end
      end
      sphpf_pkg::ST_EPS: begin
        if (mdone_q) begin
          if (r_w >= radius_q || den_w == '0) begin
            state_d = sphpf_pkg::ST_POST;
          end else begin
            mul_start = 1'b1;
            mul_a     = {32'b0, radius_q - r_w};
            mul_b     = {32'b0, radius_q - r_w};
            state_d   = sphpf_pkg::ST_D2;
          end
        end
      end
      sphpf_pkg::ST_D2: begin
        if (mdone_q) begin
          div_start = 1'b1;
          div_num   = {{PAD_Q{1'b0}}, mmag, {FRAC_BITS{1'b0}}};
          div_den   = den_q;
          state_d   = sphpf_pkg::ST_T;
        end
      end
      sphpf_pkg::ST_T: begin
        if (ddone_q) begin
          mul_start = 1'b1;
          mul_a     = {32'b0, scale_q};
          mul_b     = {2'b0, dmag};
          state_d   = sphpf_pkg::ST_K;
        end
      end
      sphpf_pkg::ST_K: begin
        if (mdone_q) begin
          div_start = 1'b1;
          div_num   = {{PAD_P{1'b0}}, pi_q, {FRAC_BITS{1'b0}}};
          div_den   = {1'b0, rhoi_q};
          state_d   = sphpf_pkg::ST_A1;
        end
      end
      sphpf_pkg::ST_A1: begin
        if (ddone_q) begin
          div_start = 1'b1;
          div_num   = {{PAD_Q{1'b0}}, dmag, {FRAC_BITS{1'b0}}};
          div_den   = {1'b0, rhoi_q};
          state_d   = sphpf_pkg::ST_A2;
        end
      end
      sphpf_pkg::ST_A2: begin
        if (ddone_q) begin
          div_start = 1'b1;
          div_num   = {{PAD_P{1'b0}}, pj_q, {FRAC_BITS{1'b0}}};
          div_den   = {1'b0, rhoj_q};
          state_d   = sphpf_pkg::ST_B1;
        end
      end
      sphpf_pkg::ST_B1: begin
        if (ddone_q) begin
          div_start = 1'b1;
          div_num   = {{PAD_Q{1'b0}}, dmag, {FRAC_BITS{1'b0}}};
          div_den   = {1'b0, rhoj_q};
          state_d   = sphpf_pkg::ST_B2;
        end
      end
      sphpf_pkg::ST_B2: begin
        if (ddone_q) begin
          mul_start = 1'b1;
          mul_a     = {32'b0, mj_q};
          mul_b     = {2'b0, ab_sat};
          state_d   = sphpf_pkg::ST_C;
        end
      end
      sphpf_pkg::ST_C: begin
        if (mdone_q) begin
          mul_start = 1'b1;
          mul_a     = {2'b0, k_q};
          mul_b     = {31'b0, ax_w};
          state_d   = sphpf_pkg::ST_GX;
        end
      end
      sphpf_pkg::ST_GX: begin
        if (mdone_q) begin
          mul_start = 1'b1;
          mul_a     = {2'b0, c_q};
          mul_b     = {2'b0, mmag};
          state_d   = sphpf_pkg::ST_FX;
        end
      end
      sphpf_pkg::ST_FX: begin
        if (mdone_q) begin
          mul_start = 1'b1;
          mul_a     = {2'b0, k_q};
          mul_b     = {31'b0, ay_w};
          state_d   = sphpf_pkg::ST_GY;
        end
      end
      sphpf_pkg::ST_GY: begin
        if (mdone_q) begin
          mul_start = 1'b1;
          mul_a     = {2'b0, c_q};
          mul_b     = {2'b0, mmag};
          state_d   = sphpf_pkg::ST_FY;
        end
      end
      sphpf_pkg::ST_FY: begin
        if (mdone_q) begin
          state_d = sphpf_pkg::ST_POST;
        end
      end
      sphpf_pkg::ST_POST: begin
        if (last_q) begin
          mul_start = 1'b1;
          mul_a     = {32'b0, mi_q};
          mul_b     = abs_x;
          state_d   = sphpf_pkg::ST_EX;
        end else begin
          state_d = sphpf_pkg::ST_IDLE;
        end
      end
      sphpf_pkg::ST_EX: begin
        if (mdone_q) begin
          mul_start = 1'b1;
          mul_a     = {32'b0, mi_q};
          mul_b     = abs_y;
          state_d   = sphpf_pkg::ST_EY;
        end
      end
      sphpf_pkg::ST_EY: begin
        if (mdone_q) begin
          state_d = sphpf_pkg::ST_OUT;
        end
      end
      sphpf_pkg::ST_OUT: begin
        if (out_load) begin
          state_d = sphpf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sphpf_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = state_q == sphpf_pkg::ST_IDLE;

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      dx_q   <= in_dx;
      dy_q   <= in_dy;
      mi_q   <= center_mass_i;
      mj_q   <= other_mass_i;
      pi_q   <= center_pressure_i;
      pj_q   <= other_pressure_i;
      // A zero density counts as one raw unit.
      rhoi_q <= (center_density_i == '0) ? 32'd1 : center_density_i;
      rhoj_q <= (other_density_i == '0) ? 32'd1 : other_density_i;
      last_q <= last_pair_i;
    end
    if (state_q == sphpf_pkg::ST_SQX && mdone_q) begin
      sqx_q <= macc_q[63:0];
    end
    if (state_q == sphpf_pkg::ST_EPS && mdone_q) begin
      den_q <= den_w;
    end
    if (state_q == sphpf_pkg::ST_K && mdone_q) begin
      k_q <= k3_w;
    end
    if (state_q == sphpf_pkg::ST_A2 && ddone_q) begin
      a_q <= dmag;
    end
    if (state_q == sphpf_pkg::ST_C && mdone_q) begin
      c_q <= mmag;
    end
    if (state_q == sphpf_pkg::ST_EX && mdone_q) begin
      fx_tmp_q <= fxr.value;
      eclip_q  <= fxr.clip || mclip;
    end
    if (state_q == sphpf_pkg::ST_EY && mdone_q) begin
      fy_tmp_q <= fyr.value;
      eclip_q  <= eclip_q || fyr.clip || mclip;
    end
    if (out_load) begin
      force_x_q   <= fx_tmp_q;
      force_y_q   <= fy_tmp_q;
      saturated_q <= eclip_q || clip_seen_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= sphpf_pkg::RADIUS_RESET;
      scale_q     <= sphpf_pkg::SCALE_RESET;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      clip_seen_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sphpf_pkg::CFG_SMOOTHING_RADIUS: radius_q <= cfg_wdata_i;
          sphpf_pkg::CFG_KERNEL_SCALE:     scale_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (state_q == sphpf_pkg::ST_FX && mdone_q) begin
        sum_x_q <= accx.value;
      end
      if (state_q == sphpf_pkg::ST_FY && mdone_q) begin
        sum_y_q <= accy.value;
      end
      if ((mdone_q && mclip && (state_q inside {sphpf_pkg::ST_D2, sphpf_pkg::ST_K,
                                                sphpf_pkg::ST_C, sphpf_pkg::ST_GX,
                                                sphpf_pkg::ST_FX, sphpf_pkg::ST_GY,
                                                sphpf_pkg::ST_FY})) ||
          (ddone_q && dclip && (state_q inside {sphpf_pkg::ST_T, sphpf_pkg::ST_A1,
                                                sphpf_pkg::ST_A2, sphpf_pkg::ST_B1,
                                                sphpf_pkg::ST_B2})) ||
          (state_q == sphpf_pkg::ST_K && mdone_q && kclip) ||
          (state_q == sphpf_pkg::ST_B2 && ddone_q && abclip) ||
          (state_q == sphpf_pkg::ST_FX && mdone_q && accx.clip) ||
          (state_q == sphpf_pkg::ST_FY && mdone_q && accy.clip)) begin
        clip_seen_q <= 1'b1;
      end
      if (out_load) begin
        sum_x_q     <= '0;
        sum_y_q     <= '0;
        clip_seen_q <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign force_x_o   = force_x_q;
  assign force_y_o   = force_y_q;
  assign saturated_o = saturated_q;

  // ---------------------------------------------------------------- assertions
  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mbusy_q && dbusy_q) && !(mbusy_q && sbusy_q) && !(dbusy_q && sbusy_q))
    else $error("Two arithmetic units are busy at once.");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != sphpf_pkg::ST_IDLE))
    else $error("Sequencer stayed idle after a transaction was accepted.");

  a_sum_symmetric: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_x_q != 64'sh8000_0000_0000_0000) && (sum_y_q != 64'sh8000_0000_0000_0000))
    else $error("Accumulator reached the unbalanced negative limit.");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_o && sum_x_q == '0 && sum_y_q == '0 && !clip_seen_q))
    else $error("Emission did not present a result and clear the accumulators.");

endmodule

// ===== verif/sphpf_checker.sv =====
`timescale 1ns / 1ps

module sphpf_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic [31:0]        center_mass_i,
  input  logic [31:0]        center_density_i,
  input  logic [31:0]        center_pressure_i,
  input  logic signed [31:0] other_x_i,
  input  logic signed [31:0] other_y_i,
  input  logic [31:0]        other_mass_i,
  input  logic [31:0]        other_density_i,
  input  logic [31:0]        other_pressure_i,
  input  logic               last_pair_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] force_x_i,
  input  logic signed [31:0] force_y_i,
  input  logic               saturated_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 forces_seen_o,
  output int                 clipped_seen_o
);

  localparam int unsigned FRAC = 16;
  localparam logic [63:0] CAP = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic               sat;
  } force_t;

  force_t force_q[$];
  logic [63:0] radius, scale;
  longint acc_x, acc_y;
  bit clip_flag;

  assign pending_o = force_q.size();

  function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b,
                                        inout bit clip);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> FRAC;
    if (p > {64'd0, CAP}) begin
      clip = 1;
      return CAP;
    end
    return p[63:0];
  endfunction

  function automatic logic [63:0] div_q(input logic [63:0] n, input logic [63:0] d,
                                        inout bit clip);
    logic [127:0] q;
    q = ({64'd0, n} << FRAC) / {64'd0, d};
    if (q > {64'd0, CAP}) begin
      clip = 1;
      return CAP;
    end
    return q[63:0];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] press_term(input logic [31:0] p, input logic [31:0] rho,
                                             inout bit clip);
    logic [63:0] d, q;
    d = (rho == 0) ? 64'd1 : {32'd0, rho};
    q = div_q({32'd0, p}, d, clip);
    return div_q(q, d, clip);
  endfunction

  function automatic longint add_sat(input longint s, input bit neg, input logic [63:0] mag,
                                     inout bit clip);
    logic signed [65:0] v;
    v = neg ? (66'(s) - $signed({2'b0, mag})) : (66'(s) + $signed({2'b0, mag}));
    if (v > 66'(SUM_MAX)) begin
      clip = 1;
      return SUM_MAX;
    end
    if (v < -66'(SUM_MAX)) begin
      clip = 1;
      return -SUM_MAX;
    end
    return longint'(v);
  endfunction

  function automatic logic [31:0] force_comp(input logic [31:0] mi, input longint s,
                                             inout bit clip);
    logic [63:0] mag;
    longint f;
    mag = mul_q({32'd0, mi}, (s < 0) ? -s : s, clip);
    f = (s < 0) ? longint'(mag) : -longint'(mag);
    if (f > 64'sh7FFF_FFFF) begin
      clip = 1;
      return 32'h7FFF_FFFF;
    end
    if (f < -64'sh8000_0000) begin
      clip = 1;
      return 32'h8000_0000;
    end
    return f[31:0];
  endfunction

  // Accumulates one neighbor pair; on the last pair queues the expected force.
  task automatic accumulate_pair();
    bit clip;
    longint dx, dy;
    logic [63:0] ax, ay, r, den, d, d2, t, k, ab, c, gx, gy;
    logic [64:0] sq;
    force_t exp_f;
    clip = 0;
    dx = longint'(center_x_i) - longint'(other_x_i);
    dy = longint'(center_y_i) - longint'(other_y_i);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax <= 64'hFFFF_FFFF && ay <= 64'hFFFF_FFFF) begin
      sq = {1'b0, ax * ax} + {1'b0, ay * ay};
      if (!sq[64]) begin
        r = int_sqrt(sq[63:0]);
        den = r + radius / 1000000;
        if (r < radius && den != 0) begin
          d = radius - r;
          d2 = mul_q(d, d, clip);
          t = div_q(d2, den, clip);
          k = mul_q(scale, t, clip);
          ab = press_term(center_pressure_i, center_density_i, clip) +
               press_term(other_pressure_i, other_density_i, clip);
          if (k > CAP / 3) begin
            clip = 1;
            k = CAP;
          end else begin
            k = k * 3;
          end
          if (ab > CAP) begin
            clip = 1;
            ab = CAP;
          end
          c = mul_q({32'd0, other_mass_i}, ab, clip);
          gx = mul_q(k, ax, clip);
          gy = mul_q(k, ay, clip);
          // The contribution points against the offset.
          acc_x = add_sat(acc_x, dx > 0, mul_q(c, gx, clip), clip);
          acc_y = add_sat(acc_y, dy > 0, mul_q(c, gy, clip), clip);
        end
      end
    end
    if (clip) clip_flag = 1;
    if (last_pair_i) begin
      clip = 0;
      exp_f.fx = force_comp(center_mass_i, acc_x, clip);
      exp_f.fy = force_comp(center_mass_i, acc_y, clip);
      exp_f.sat = clip | clip_flag;
      force_q.push_back(exp_f);
      acc_x = 0;
      acc_y = 0;
      clip_flag = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius = {32'd0, sphpf_pkg::RADIUS_RESET};
      scale = {32'd0, sphpf_pkg::SCALE_RESET};
      acc_x = 0;
      acc_y = 0;
      clip_flag = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == sphpf_pkg::CFG_SMOOTHING_RADIUS) radius = {32'd0, cfg_wdata_i};
        else scale = {32'd0, cfg_wdata_i};
      end
      if (in_valid_i && in_ready_i) accumulate_pair();
    end
  end

  initial begin
    fail_count_o = 0;
    forces_seen_o = 0;
    clipped_seen_o = 0;
  end

  always @(posedge clk_i) begin
    force_t exp_f;
    if (rst_ni && out_valid_i && out_ready_i) begin
      forces_seen_o++;
      if (saturated_i) clipped_seen_o++;
      if (force_q.size() == 0) begin
        $display("%0t: unexpected force transaction fx=%h fy=%h sat=%b",
                 $time, force_x_i, force_y_i, saturated_i);
        fail_count_o++;
      end else begin
        exp_f = force_q.pop_front();
        if (force_x_i !== exp_f.fx) begin
          $display("%0t: force_x expected %h actual %h", $time, exp_f.fx, force_x_i);
          fail_count_o++;
        end
        if (force_y_i !== exp_f.fy) begin
          $display("%0t: force_y expected %h actual %h", $time, exp_f.fy, force_y_i);
          fail_count_o++;
        end
        if (saturated_i !== exp_f.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, exp_f.sat, saturated_i);
          fail_count_o++;
        end
      end
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int LIMIT_CYCLES = 4000000;
  localparam int SETTLE_CYCLES = 800;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [0:0] cfg_idx_i = sphpf_pkg::CFG_SMOOTHING_RADIUS;
  logic [31:0] cfg_wdata_i = 0;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic signed [31:0] center_x_i = 0, center_y_i = 0, other_x_i = 0, other_y_i = 0;
  logic [31:0] center_mass_i = 0, center_density_i = 1, center_pressure_i = 0;
  logic [31:0] other_mass_i = 0, other_density_i = 1, other_pressure_i = 0;
  logic last_pair_i = 0;
  logic out_valid_o;
  logic out_ready_i = 1;
  logic signed [31:0] force_x_o, force_y_o;
  logic saturated_o;

  int fail_count, pending, forces_seen, clipped_seen;
  int cycles = 0;
  int burst_left = 0;
  int pairs_sent = 0;
  logic [31:0] cur_radius = sphpf_pkg::RADIUS_RESET;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  sph_pressure_force_accumulator uut (.*);

  sphpf_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o),
    .center_x_i, .center_y_i, .center_mass_i, .center_density_i, .center_pressure_i,
    .other_x_i, .other_y_i, .other_mass_i, .other_density_i, .other_pressure_i,
    .last_pair_i, .out_valid_i(out_valid_o), .out_ready_i,
    .force_x_i(force_x_o), .force_y_i(force_y_o), .saturated_i(saturated_o),
    .fail_count_o(fail_count), .pending_o(pending),
    .forces_seen_o(forces_seen), .clipped_seen_o(clipped_seen)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // The receiver alternates between always-ready stretches and random stalls.
  int stall_mode = 0;
  int mode_left = 0;
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 300);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      default: out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_pair(input logic [31:0] cx, cy, cm, cd, cp, ox, oy, om, od, op,
                           input bit last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 30);
      burst_left = $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i = 0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    center_x_i = cx;
    center_y_i = cy;
    center_mass_i = cm;
    center_density_i = cd;
    center_pressure_i = cp;
    other_x_i = ox;
    other_y_i = oy;
    other_mass_i = om;
    other_density_i = od;
    other_pressure_i = op;
    last_pair_i = last;
    in_valid_i = 1;
    do @(posedge clk_i); while (!in_ready_o);
    pairs_sent++;
    @(negedge clk_i);
  endtask

  // Registers change only when no force is outstanding and the last pair has drained.
  task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
    in_valid_i = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i = 1;
    cfg_idx_i = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 0;
    if (idx == sphpf_pkg::CFG_SMOOTHING_RADIUS) cur_radius = value;
  endtask

  function automatic logic [31:0] rand_density();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(32'h0000_1000, 32'h0010_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_quantity(input logic [31:0] typical);
    case ($urandom_range(0, 11))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(0, typical);
    endcase
  endfunction

  function automatic logic [31:0] rand_offset();
    logic [31:0] lim, v;
    lim = cur_radius >> 1;
    if (lim > 32'h4000_0000) lim = 32'h4000_0000;
    v = $urandom_range(0, lim);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  task automatic random_neighborhoods(input int pairs);
    int n, group;
    logic [31:0] cx, cy, cm, cd, cp, ox, oy;
    n = 0;
    while (n < pairs) begin
      group = $urandom_range(1, 8);
      cx = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 32'h2000_0000);
      cy = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 32'h2000_0000);
      cm = rand_quantity(32'h0004_0000);
      cd = rand_density();
      cp = rand_quantity(32'h0040_0000);
      for (int i = 0; i < group; i++) begin
        // Most neighbors lie inside the support; a few are arbitrary noise.
        if ($urandom_range(0, 7) == 0) begin
          ox = $urandom();
          oy = $urandom();
        end else begin
          ox = cx - rand_offset();
          oy = cy - rand_offset();
        end
        send_pair(cx, cy, cm, cd, cp, ox, oy, rand_quantity(32'h0004_0000),
                  rand_density(), rand_quantity(32'h0040_0000), i == group - 1);
        n++;
      end
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed pairs with h = 1.0 and scale = 1.0 out of reset.
    send_pair(0, 0, 32'h10000, 32'h10000, 32'h10000, 0, 0, 32'h10000, 32'h10000,
              32'h10000, 1);  // coincident particles
    send_pair(0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 0, 32'h10000,
              32'h10000, 32'h10000, 1);  // exactly at the support edge
    send_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h10000, 32'h10000, 32'h10000,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h10000, 32'h10000, 32'h10000, 1);
    send_pair(0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h4000, 32'hFFFF_C000,
              32'h10000, 32'h10000, 32'h10000, 0);
    send_pair(0, 0, 32'h10000, 32'h10000, 32'h10000, 32'hFFFF_A000, 32'h3000,
              32'h10000, 32'h10000, 32'h10000, 1);
    send_pair(0, 0, 32'h10000, 32'h0, 32'hFFFF_FFFF, 32'h100, 32'h0, 32'hFFFF_FFFF,
              32'h0, 32'hFFFF_FFFF, 1);  // zero densities, heavy clipping
    send_pair(32'h100, 32'h0, 32'h0, 32'h10000, 32'h10000, 0, 0, 32'h10000,
              32'h10000, 32'h10000, 1);  // zero center mass
    send_pair(0, 0, 32'hFFFF_FFFF, 32'h1000, 32'h0100_0000, 32'h2000, 32'h2000,
              32'h00FF_0000, 32'h1000, 32'h0100_0000, 1);  // output clip
    send_pair(0, 32'h8000, 32'h10000, 32'h10000, 32'h0, 0, 0, 32'h0, 32'hFFFF_FFFF,
              32'h0, 1);
    write_reg(sphpf_pkg::CFG_SMOOTHING_RADIUS, 32'h0000_0001);
    send_pair(0, 0, 32'h10000, 32'h10000, 32'h10000, 0, 0, 32'h10000, 32'h10000,
              32'h10000, 1);
    send_pair(0, 0, 32'h10000, 32'h10000, 32'h10000, 1, 0, 32'h10000, 32'h10000,
              32'h10000, 1);
    write_reg(sphpf_pkg::CFG_SMOOTHING_RADIUS, 32'hFFFF_FFFF);
    write_reg(sphpf_pkg::CFG_KERNEL_SCALE, 32'hFFFF_FFFF);
    send_pair(0, 0, 32'h10000, 32'h10000, 32'h10000, 0, 0, 32'h10000, 32'h10000,
              32'h10000, 1);  // coincident, h*eps nonzero
    send_pair(32'h4000_0000, 0, 32'h10000, 32'h10000, 32'h10000, 0, 32'h4000_0000,
              32'h10000, 32'h10000, 32'h10000, 1);
    write_reg(sphpf_pkg::CFG_KERNEL_SCALE, 32'h0);
    send_pair(0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h1000, 32'h1000, 32'h10000,
              32'h10000, 32'h10000, 1);

    // Random neighborhoods under several register settings.
    random_neighborhoods(60);
    write_reg(sphpf_pkg::CFG_SMOOTHING_RADIUS, 32'h0001_0000);
    write_reg(sphpf_pkg::CFG_KERNEL_SCALE, 32'h0001_0000);
    random_neighborhoods(120);
    write_reg(sphpf_pkg::CFG_SMOOTHING_RADIUS, 32'h0008_0000);
    write_reg(sphpf_pkg::CFG_KERNEL_SCALE, 32'hFFFF_FFFF);
    random_neighborhoods(80);
    write_reg(sphpf_pkg::CFG_SMOOTHING_RADIUS, $urandom_range(1, 32'h0100_0000));
    write_reg(sphpf_pkg::CFG_KERNEL_SCALE, $urandom());
    random_neighborhoods(80);
    write_reg(sphpf_pkg::CFG_SMOOTHING_RADIUS, 32'h0000_0001);
    random_neighborhoods(20);
    write_reg(sphpf_pkg::CFG_SMOOTHING_RADIUS, 32'h0002_0000);
    write_reg(sphpf_pkg::CFG_KERNEL_SCALE, 32'h0003_0000);
    random_neighborhoods(60);

    in_valid_i = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    $display("Sent %0d neighbor pairs; checked %0d force transactions, %0d of them clipped.",
             pairs_sent, forces_seen, clipped_seen);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/sphpf_pkg.sv
sv/sph_pressure_force_accumulator.sv
verif/sphpf_checker.sv
verif/testbench.sv
